FILE: sv/uer_pkg.sv
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// register codes, status codes, reset values and the fixed-point scaling constants
// no dependencies
`default_nettype none

package uer_pkg;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET  = 2'd0,
		REG_MAX_CM  = 2'd1,
		REG_MIN_CM  = 2'd2,
		REG_TRIGGER = 2'd3
	} reg_idx_t;

	// measurement status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAR  = 2'd1,
		ST_NEAR = 2'd2
	} status_t;

	// register reset values
	localparam logic [15:0] OFFSET_RST  = 16'd5703;
	localparam logic [9:0]  MAX_CM_RST  = 10'd300;
	localparam logic [9:0]  MIN_CM_RST  = 10'd3;
	localparam logic [9:0]  TRIGGER_RST = 10'd10;

	// distance limits
	localparam logic [9:0] DIST_MAX  = 10'd1023;
	localparam logic [9:0] DIGIT_CAP = 10'd999;

	// distance = (ticks * 43) / 30000, saturated at 1023
	// ticks >= SAT_DIFF is exactly the set where the quotient exceeds 1023
	localparam int unsigned MUL_K       = 43;
	localparam int unsigned SAT_DIFF    = 714419;
	localparam int unsigned DIFF_LO_W   = 20;
	localparam int unsigned PROD_W      = 25;
	// ceil(2^40 / 30000); exact floor division for any product below 2^25
	localparam int unsigned RECIP_W     = 26;
	localparam logic [RECIP_W-1:0] RECIP_M = 26'd36650388;
	localparam int unsigned RECIP_SHIFT = 40;

	// decimal split by reciprocal: x/100 = (x*41)>>12 for x < 1000, x/10 = (x*205)>>11
	localparam logic [5:0] RECIP_100 = 6'd41;
	localparam logic [7:0] RECIP_10  = 8'd205;

	typedef struct packed {
		logic [15:0] offset_ticks;
		logic [9:0]  max_cm;
		logic [9:0]  min_cm;
		logic [9:0]  trigger_ticks;
	} cfg_t;

	typedef struct packed {
		logic trigger;
		logic busy;
		logic done;
	} flags_t;

	// control stage to scaling stages
	typedef struct packed {
		flags_t               flags;
		logic                 far;
		logic                 sat;
		logic [DIFF_LO_W-1:0] diff_lo;
	} meas_t;

	// scaling stages to digit stages
	typedef struct packed {
		flags_t     flags;
		logic [1:0] status;
		logic [9:0] distance;
		logic [9:0] value;
	} shown_t;

	// one finished result
	typedef struct packed {
		flags_t     flags;
		logic [1:0] status;
		logic [9:0] distance;
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
		logic       hundreds_shown;
		logic       tens_shown;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/uer_ctrl.sv
// uer_ctrl: input register, trigger/count sequencer and offset subtraction
// depends on uer_pkg
`default_nettype none

module uer_ctrl import uer_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        take,
	input  wire logic        start_req,
	input  wire logic        echo,
	input  wire logic [15:0] offset_ticks,
	input  wire logic [9:0]  trigger_ticks,
	output logic             meas_valid,
	output meas_t            meas
);

	localparam int unsigned DW = (COUNT_WIDTH > DIFF_LO_W) ? COUNT_WIDTH : DIFF_LO_W;

	logic                   v_s1;
	logic                   start_s1;
	logic                   echo_s1;

	logic [COUNT_WIDTH-1:0] tick_q;
	logic                   measuring_q;
	logic [9:0]             pulse_q;

	logic [COUNT_WIDTH-1:0] tick_n;
	logic                   measuring_n;
	logic [9:0]             pulse_n;
	logic                   done;
	logic [COUNT_WIDTH-1:0] off_w;

	logic                   v_s2;
	flags_t                 flags_s2;
	logic                   far_s2;
	logic [COUNT_WIDTH-1:0] diff_s2;
	logic [DW-1:0]          diff_w;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_s1 <= start_req;
			echo_s1  <= echo;
		end
	end

	// next state of the sequencer: pulse, then counting, then idle
	always_comb begin
		tick_n      = tick_q;
		measuring_n = measuring_q;
		pulse_n     = pulse_q;
		done        = 1'b0;
		if (pulse_q != 10'd0) begin
			pulse_n = pulse_q - 10'd1;
			if (pulse_n == 10'd0) begin
				measuring_n = 1'b1;
			end
		end else if (measuring_q) begin
			if (echo_s1) begin
				done        = 1'b1;
				measuring_n = 1'b0;
			end else begin
				tick_n = tick_q + COUNT_WIDTH'(1);
			end
		end else if (start_s1) begin
			tick_n  = '0;
			pulse_n = (trigger_ticks == 10'd0) ? 10'd1 : trigger_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			measuring_q <= 1'b0;
			pulse_q     <= 10'd0;
		end else if (en && v_s1) begin
			tick_q      <= tick_n;
			measuring_q <= measuring_n;
			pulse_q     <= pulse_n;
		end
	end

	// offset subtraction on the count that ends the measurement
	assign off_w = COUNT_WIDTH'(offset_ticks);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			flags_s2.trigger <= (pulse_n != 10'd0);
			flags_s2.busy    <= measuring_n;
			flags_s2.done    <= done;
			far_s2           <= (tick_q < off_w);
			diff_s2          <= tick_q - off_w;
		end
	end

	// saturation test on the difference
	assign diff_w       = DW'(diff_s2);
	assign meas_valid   = v_s2;
	assign meas.flags   = flags_s2;
	assign meas.far     = far_s2;
	assign meas.sat     = (diff_w >= DW'(SAT_DIFF));
	assign meas.diff_lo = diff_w[DIFF_LO_W-1:0];

endmodule

`default_nettype wire

FILE: sv/uer_scale.sv
// uer_scale: ticks to centimetres, range classification and last-distance hold
// depends on uer_pkg
`default_nettype none

module uer_scale import uer_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       meas_valid,
	input  meas_t           meas,
	input  wire logic [9:0] max_cm,
	input  wire logic [9:0] min_cm,
	output logic            shown_valid,
	output shown_t          shown
);

	localparam int unsigned QW = PROD_W + RECIP_W;

	logic                 v_s3;
	flags_t               flags_s3;
	logic                 far_s3;
	logic                 sat_s3;
	logic [PROD_W-1:0]    prod_s3;
	logic [PROD_W:0]      prod_full;

	logic                 v_s4;
	flags_t               flags_s4;
	logic                 far_s4;
	logic                 sat_s4;
	logic [9:0]           quot_s4;
	logic [QW-1:0]        recip_prod;

	logic [9:0]           dist_new;
	logic [1:0]           st_new;
	logic [9:0]           dist_eff;
	logic [1:0]           st_eff;
	logic [9:0]           last_dist_q;
	logic [1:0]           last_status_q;

	logic                 v_s5;
	shown_t               shown_s5;

	// ticks times 43
	assign prod_full = PROD_W'(meas.diff_lo) * (PROD_W + 1)'(MUL_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= meas_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en && meas_valid) begin
			flags_s3 <= meas.flags;
			far_s3   <= meas.far;
			sat_s3   <= meas.sat;
			prod_s3  <= prod_full[PROD_W-1:0];
		end
	end

	// divide by 30000 through the reciprocal
	assign recip_prod = QW'(prod_s3) * QW'(RECIP_M);

	always_ff @(posedge clk) begin
		if (en && v_s3) begin
			flags_s4 <= flags_s3;
			far_s4   <= far_s3;
			sat_s4   <= sat_s3;
			quot_s4  <= recip_prod[RECIP_SHIFT +: 10];
		end
	end

	// saturate and classify, too far before too near
	always_comb begin
		dist_new = (far_s4 || sat_s4) ? DIST_MAX : quot_s4;
		if (far_s4 || (dist_new > max_cm)) begin
			st_new = ST_FAR;
		end else if (dist_new < min_cm) begin
			st_new = ST_NEAR;
		end else begin
			st_new = ST_OK;
		end
		dist_eff = flags_s4.done ? dist_new : last_dist_q;
		st_eff   = flags_s4.done ? st_new : last_status_q;
	end

	// last measurement hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dist_q   <= 10'd0;
			last_status_q <= ST_OK;
		end else if (en && v_s4 && flags_s4.done) begin
			last_dist_q   <= dist_new;
			last_status_q <= st_new;
		end
	end

	// value for the digit display, blank unless in range
	always_ff @(posedge clk) begin
		if (en && v_s4) begin
			shown_s5.flags    <= flags_s4;
			shown_s5.status   <= st_eff;
			shown_s5.distance <= dist_eff;
			if (st_eff != ST_OK) begin
				shown_s5.value <= 10'd0;
			end else if (dist_eff > DIGIT_CAP) begin
				shown_s5.value <= DIGIT_CAP;
			end else begin
				shown_s5.value <= dist_eff;
			end
		end
	end

	assign shown_valid = v_s5;
	assign shown       = shown_s5;

endmodule

`default_nettype wire

FILE: sv/uer_digits.sv
// uer_digits: decimal split of the displayed distance with leading-zero blanking
// depends on uer_pkg
`default_nettype none

module uer_digits import uer_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic shown_valid,
	input  shown_t    shown,
	output logic      res_valid,
	output result_t   res
);

	logic [15:0] hund_prod;
	logic [3:0]  hund;
	logic [9:0]  hund_rem;

	logic        v_s6;
	flags_t      flags_s6;
	logic [1:0]  status_s6;
	logic [9:0]  dist_s6;
	logic [3:0]  hund_s6;
	logic [6:0]  rem_s6;

	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [6:0]  ones_w;

	// hundreds digit and remainder
	assign hund_prod = 16'(shown.value) * 16'(RECIP_100);
	assign hund      = hund_prod[15:12];
	assign hund_rem  = shown.value - 10'(hund) * 10'd100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= shown_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && shown_valid) begin
			flags_s6  <= shown.flags;
			status_s6 <= shown.status;
			dist_s6   <= shown.distance;
			hund_s6   <= hund;
			rem_s6    <= hund_rem[6:0];
		end
	end

	// tens and ones from the remainder
	assign tens_prod = 15'(rem_s6) * 15'(RECIP_10);
	assign tens      = tens_prod[14:11];
	assign ones_w    = rem_s6 - 7'(tens) * 7'd10;

	assign res_valid          = v_s6;
	assign res.flags          = flags_s6;
	assign res.status         = status_s6;
	assign res.distance       = dist_s6;
	assign res.hundreds       = hund_s6;
	assign res.tens           = tens;
	assign res.ones           = ones_w[3:0];
	assign res.hundreds_shown = (hund_s6 != 4'd0);
	assign res.tens_shown     = (tens != 4'd0) || (hund_s6 != 4'd0);

endmodule

`default_nettype wire

FILE: sv/uer_skid.sv
// uer_skid: output register with a one-entry skid buffer
// depends on uer_pkg
`default_nettype none

module uer_skid import uer_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_valid,
	input  result_t   res,
	input  wire logic out_stall,
	output logic      out_valid,
	output result_t   out_res,
	output logic      full
);

	logic    out_valid_q;
	logic    full_q;
	result_t out_q;
	result_t skid_q;

	// occupancy of output and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			full_q      <= 1'b0;
		end else if (!full_q) begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= res_valid;
			end else if (res_valid) begin
				full_q <= 1'b1;
			end
		end else if (!out_stall) begin
			full_q <= 1'b0;
		end
	end

	// payload moves
	always_ff @(posedge clk) begin
		if (!full_q) begin
			if (!out_valid_q || !out_stall) begin
				out_q <= res;
			end else if (res_valid) begin
				skid_q <= res;
			end
		end else if (!out_stall) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign full      = full_q;

endmodule

`default_nettype wire

FILE: sv/ultrasonic_echo_ranger.sv
// ultrasonic_echo_ranger: top level, configuration registers and pipeline wiring
// depends on uer_pkg, uer_ctrl, uer_scale, uer_digits, uer_skid
//
// Usage:
// - one input request per timer tick on in_valid/in_stall, carrying start_req
//   and the echo level; every accepted request yields exactly one result
// - the result carries the trigger level, busy and done flags, the status and
//   distance of the last measurement and its decimal digits with blanking
// - configuration is written through cfg_we/cfg_index/cfg_wdata while idle
// - throughput is one request per cycle while in_stall is low; from the
//   accepting edge (which loads the input register) to out_valid a request
//   passes the six register stages after it: offset subtract, multiply by 43,
//   reciprocal multiply, classify, digit split and the output register
// - the control sequencer feeds its next state straight back into its state
//   registers, so ticks may arrive in every cycle while in_stall is low
// - when out_stall holds a result, one more result lands in the skid entry,
//   then in_stall rises and the whole pipeline holds until the skid drains
// - reset clears the sequencer, the last measurement, the pipeline and the
//   output; the registers return to their default values
`default_nettype none

module ultrasonic_echo_ranger import uer_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  start_req,
	input  wire logic                  echo,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       trigger,
	output logic                       busy_res,
	output logic                       done_res,
	output logic [1:0]                 status,
	output logic [9:0]                 distance_cm,
	output logic [3:0]                 hundreds_digit,
	output logic [3:0]                 tens_digit,
	output logic [3:0]                 ones_digit,
	output logic                       hundreds_shown,
	output logic                       tens_shown
);

	cfg_t    cfg_q;
	logic    en;
	logic    take;
	logic    full;
	logic    meas_valid;
	meas_t   meas;
	logic    shown_valid;
	shown_t  shown;
	logic    res_valid;
	result_t res;
	result_t out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_ticks  <= OFFSET_RST;
			cfg_q.max_cm        <= MAX_CM_RST;
			cfg_q.min_cm        <= MIN_CM_RST;
			cfg_q.trigger_ticks <= TRIGGER_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_OFFSET:  cfg_q.offset_ticks  <= cfg_wdata;
				REG_MAX_CM:  cfg_q.max_cm        <= cfg_wdata[9:0];
				REG_MIN_CM:  cfg_q.min_cm        <= cfg_wdata[9:0];
				REG_TRIGGER: cfg_q.trigger_ticks <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	// pipeline advances while the skid entry is empty
	assign en       = !full;
	assign in_stall = full;
	assign take     = in_valid && !full;

	uer_ctrl #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.take         (take),
		.start_req    (start_req),
		.echo         (echo),
		.offset_ticks (cfg_q.offset_ticks),
		.trigger_ticks(cfg_q.trigger_ticks),
		.meas_valid   (meas_valid),
		.meas         (meas)
	);

	uer_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.meas_valid (meas_valid),
		.meas       (meas),
		.max_cm     (cfg_q.max_cm),
		.min_cm     (cfg_q.min_cm),
		.shown_valid(shown_valid),
		.shown      (shown)
	);

	uer_digits u_digits (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.shown_valid(shown_valid),
		.shown      (shown),
		.res_valid  (res_valid),
		.res        (res)
	);

	uer_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_res  (out_res),
		.full     (full)
	);

	// result fields
	assign trigger        = out_res.flags.trigger;
	assign busy_res       = out_res.flags.busy;
	assign done_res       = out_res.flags.done;
	assign status         = out_res.status;
	assign distance_cm    = out_res.distance;
	assign hundreds_digit = out_res.hundreds;
	assign tens_digit     = out_res.tens;
	assign ones_digit     = out_res.ones;
	assign hundreds_shown = out_res.hundreds_shown;
	assign tens_shown     = out_res.tens_shown;

endmodule

`default_nettype wire

FILE: sv/uer_checker.sv
// uer_checker: port-level checks on the ranger results, bound to the top level
// depends on uer_pkg and ultrasonic_echo_ranger
`default_nettype none

module uer_checker import uer_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       trigger,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic [1:0] status,
	input wire logic [3:0] hundreds_digit,
	input wire logic [3:0] tens_digit,
	input wire logic [3:0] ones_digit,
	input wire logic       hundreds_shown,
	input wire logic       tens_shown
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a finished measurement is neither triggering nor counting
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !trigger)
		else $error("done with trigger or busy set");

	// digits blank outside the valid range
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |->
			(hundreds_digit == 4'd0) && (tens_digit == 4'd0) && (ones_digit == 4'd0)
			&& !hundreds_shown && !tens_shown)
		else $error("digits shown for out-of-range status");

	// leading-zero blanking order
	a_shown_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hundreds_shown |-> tens_shown && (hundreds_digit != 4'd0))
		else $error("tens blanked under a shown hundreds digit");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

`default_nettype wire

FILE: sim/tb_top.sv
// tb_top: self-checking bench for ultrasonic_echo_ranger, one request per timer tick
// directed measurement plan, then random measurements under random idling on both sides
// depends on uer_pkg and ultrasonic_echo_ranger
`default_nettype none

module tb_top;
	import uer_pkg::*;

	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned SCALE_MUL   = 43;
	localparam int unsigned SCALE_DIV   = 30000;
	localparam int unsigned PIPE_WAIT   = 12;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_TICKS = 110;
	localparam int unsigned LONG_TICKS  = 5000;

	// one expected result
	typedef struct packed {
		logic       trigger;
		logic       busy;
		logic       done;
		status_t    status;
		logic [9:0] distance;
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
		logic       hundreds_shown;
		logic       tens_shown;
	} reading_t;

	// one row of the directed plan
	typedef struct packed {
		logic        wr;
		logic [15:0] offset;
		logic [9:0]  max_cm;
		logic [9:0]  min_cm;
		logic [9:0]  trig;
		logic        meas;
		logic [31:0] ticks;
		logic        typed;
		status_t     st;
		logic [9:0]  want_cm;
	} plan_row_t;

	localparam int unsigned PLAN_ROWS = 8;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// before any measurement
		'{1'b0, 16'd5703, 10'd300, 10'd3, 10'd10, 1'b0, 32'd0, 1'b1, ST_OK, 10'd0},
		// count below offset with the reset settings
		'{1'b0, 16'd5703, 10'd300, 10'd3, 10'd10, 1'b1, 32'd0, 1'b1, ST_FAR, 10'd1023},
		// zero trigger length, count equal to offset
		'{1'b1, 16'd0, 10'd300, 10'd3, 10'd0, 1'b1, 32'd0, 1'b1, ST_NEAR, 10'd0},
		// first whole centimetre, too far wins over too near
		'{1'b1, 16'd0, 10'd0, 10'd1023, 10'd2, 1'b1, 32'd698, 1'b1, ST_FAR, 10'd1},
		'{1'b1, 16'd0, 10'd1023, 10'd1023, 10'd3, 1'b1, 32'd0, 1'b1, ST_NEAR, 10'd0},
		// largest offset, count far below it
		'{1'b1, 16'd65535, 10'd1023, 10'd0, 10'd1, 1'b1, 32'd0, 1'b1, ST_FAR, 10'd1023},
		// long trigger, short count
		'{1'b1, 16'd0, 10'd1023, 10'd0, 10'd60, 1'b1, 32'd40, 1'b0, ST_OK, 10'd0},
		// both limits zero, zero distance in range
		'{1'b1, 16'd0, 10'd0, 10'd0, 10'd4, 1'b1, 32'd0, 1'b1, ST_OK, 10'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_OFFSET;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  start_req = 1'b0;
	logic                  echo = 1'b0;
	logic                  out_stall = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  trigger;
	logic                  busy_res;
	logic                  done_res;
	logic [1:0]            status;
	logic [9:0]            distance_cm;
	logic [3:0]            hundreds_digit;
	logic [3:0]            tens_digit;
	logic [3:0]            ones_digit;
	logic                  hundreds_shown;
	logic                  tens_shown;

	// ranger state as predicted
	logic [15:0]        offset_reg = OFFSET_RST;
	logic [9:0]         far_limit = MAX_CM_RST;
	logic [9:0]         near_limit = MIN_CM_RST;
	logic [9:0]         pulse_len = TRIGGER_RST;
	logic [COUNT_W-1:0] tick_total = '0;
	logic               counting = 1'b0;
	logic [9:0]         pulse_rem = '0;
	logic [9:0]         shown_dist = '0;
	status_t            shown_status = ST_OK;

	reading_t    pending_readings [$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned ticks_sent = 0;
	int unsigned hold_left = 0;
	bit          calm = 1'b0;
	logic [1:0]  seen_status = '0;
	logic [9:0]  seen_dist = '0;

	ultrasonic_echo_ranger #(.COUNT_WIDTH(COUNT_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_req(start_req),
		.echo(echo),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.trigger(trigger),
		.busy_res(busy_res),
		.done_res(done_res),
		.status(status),
		.distance_cm(distance_cm),
		.hundreds_digit(hundreds_digit),
		.tens_digit(tens_digit),
		.ones_digit(ones_digit),
		.hundreds_shown(hundreds_shown),
		.tens_shown(tens_shown)
	);

	// 20 unit clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// idle cycles before a request or after a result
	function automatic int unsigned draw_wait();
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// distance and status once the echo is seen
	function automatic void close_measurement();
		logic [63:0] scaled;
		if (tick_total < COUNT_W'(offset_reg)) begin
			shown_dist = DIST_MAX;
			shown_status = ST_FAR;
		end else begin
			scaled = (64'(tick_total - COUNT_W'(offset_reg)) * 64'(SCALE_MUL)) / 64'(SCALE_DIV);
			shown_dist = (scaled > 64'(DIST_MAX)) ? DIST_MAX : scaled[9:0];
			if (shown_dist > far_limit)
				shown_status = ST_FAR;
			else if (shown_dist < near_limit)
				shown_status = ST_NEAR;
			else
				shown_status = ST_OK;
		end
	endfunction

	// advance the ranger by one tick and give the reading it shows
	function automatic reading_t range_tick(logic s, logic e);
		reading_t   r;
		logic [9:0] v;
		logic       fin;
		fin = 1'b0;
		if (pulse_rem != 0) begin
			pulse_rem--;
			if (pulse_rem == 0)
				counting = 1'b1;
		end else if (counting) begin
			if (e) begin
				close_measurement();
				counting = 1'b0;
				fin = 1'b1;
			end else begin
				tick_total++;
			end
		end else if (s) begin
			tick_total = '0;
			pulse_rem = (pulse_len == 0) ? 10'd1 : pulse_len;
		end
		r = '0;
		r.trigger = (pulse_rem != 0);
		r.busy = counting;
		r.done = fin;
		r.status = shown_status;
		r.distance = shown_dist;
		// digits only for an in-range distance, leading zeros blanked
		if (shown_status == ST_OK) begin
			v = (shown_dist > DIGIT_CAP) ? DIGIT_CAP : shown_dist;
			r.hundreds = 4'(v / 10'd100);
			r.tens = 4'((v / 10'd10) % 10'd10);
			r.ones = 4'(v % 10'd10);
			r.hundreds_shown = (r.hundreds != 0);
			r.tens_shown = (r.tens != 0) || r.hundreds_shown;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// predict on every accepted request, check every accepted result
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_readings.push_back(range_tick(start_req, echo));
			if (out_valid && !out_stall) begin
				if (pending_readings.size() == 0) begin
					mismatches++;
					$error("result with no request outstanding");
				end else begin
					want = pending_readings.pop_front();
					check_field("trigger", want.trigger, trigger);
					check_field("busy_res", want.busy, busy_res);
					check_field("done_res", want.done, done_res);
					check_field("status", want.status, status);
					check_field("distance_cm", want.distance, distance_cm);
					check_field("hundreds_digit", want.hundreds, hundreds_digit);
					check_field("tens_digit", want.tens, tens_digit);
					check_field("ones_digit", want.ones, ones_digit);
					check_field("hundreds_shown", want.hundreds_shown, hundreds_shown);
					check_field("tens_shown", want.tens_shown, tens_shown);
				end
				seen_status = status;
				seen_dist = distance_cm;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else if (hold_left != 0) begin
			hold_left--;
			if (hold_left == 0)
				out_stall <= 1'b0;
		end else if (out_valid && !out_stall) begin
			hold_left = draw_wait();
			if (hold_left != 0)
				out_stall <= 1'b1;
		end
	end

	// watchdog on handshake progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// present one tick request and hold it until taken
	task automatic send_tick(logic s, logic e);
		int unsigned gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start_req <= s;
		echo <= e;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// write all four registers, block idle
	task automatic apply_config(logic [15:0] off, logic [9:0] mx, logic [9:0] mn, logic [9:0] tr);
		reg_idx_t idx;
		idx = REG_OFFSET;
		repeat (4) begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			case (idx)
				REG_OFFSET:  cfg_wdata <= off;
				REG_MAX_CM:  cfg_wdata <= CFG_DATA_W'(mx);
				REG_MIN_CM:  cfg_wdata <= CFG_DATA_W'(mn);
				REG_TRIGGER: cfg_wdata <= CFG_DATA_W'(tr);
				default:     cfg_wdata <= '0;
			endcase
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		offset_reg = off;
		far_limit = mx;
		near_limit = mn;
		pulse_len = tr;
	endtask

	// stop sending until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_readings.size() != 0);
	endtask

	task automatic settle();
		drain();
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	function automatic logic fill_bit(bit scramble);
		return scramble ? logic'($urandom_range(0, 1)) : 1'b1;
	endfunction

	// one full measurement: start, trigger pulse, n quiet ticks, echo
	// ignored inputs are all ones in directed rows, random otherwise
	task automatic measure(int unsigned n, bit scramble);
		int unsigned pulse_ticks;
		pulse_ticks = (pulse_len == 0) ? 1 : pulse_len;
		send_tick(1'b1, fill_bit(scramble));
		repeat (pulse_ticks) send_tick(fill_bit(scramble), fill_bit(scramble));
		repeat (n) send_tick(fill_bit(scramble), 1'b0);
		send_tick(fill_bit(scramble), 1'b1);
		ticks_sent += n + pulse_ticks + 2;
	endtask

	initial begin
		plan_row_t   row;
		int unsigned pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		for (int i = 0; i < PLAN_ROWS; i++) begin
			row = PLAN[i];
			if (row.wr)
				apply_config(row.offset, row.max_cm, row.min_cm, row.trig);
			calm = (row.ticks > LONG_TICKS);
			if (row.meas) begin
				measure(row.ticks, 1'b0);
			end else begin
				send_tick(1'b0, 1'b1);
				send_tick(1'b0, 1'b0);
			end
			settle();
			calm = 1'b0;
			if (row.typed) begin
				check_field("status", row.st, seen_status);
				check_field("distance_cm", row.want_cm, seen_dist);
			end
		end

		// random phases, each with its own settings
		ticks_sent = 0;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: apply_config(16'($urandom_range(0, 40)), 10'd1023, 10'd0,
					10'($urandom_range(1, 4)));
				1: apply_config(16'($urandom_range(0, 40)), 10'd0, 10'd1,
					10'($urandom_range(1, 6)));
				2: apply_config(16'($urandom), 10'($urandom_range(0, 1023)),
					10'($urandom_range(0, 1023)), 10'($urandom_range(1, 3)));
				default: apply_config(16'($urandom_range(0, 40)), 10'($urandom_range(0, 3)),
					10'($urandom_range(0, 3)), 10'($urandom_range(1, 8)));
			endcase
			while (ticks_sent < PHASE_TICKS * (p + 1)) begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					// idle noise, start low
					repeat ($urandom_range(1, 4)) send_tick(1'b0, logic'($urandom_range(0, 1)));
				end else begin
					if (pick == 2 && $urandom_range(0, 3) == 0)
						drain();
					if (pick == 3 && $urandom_range(0, 7) == 0)
						measure($urandom_range(690, 760), 1'b1);
					else
						measure($urandom_range(0, 60), 1'b1);
				end
			end
			settle();
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
